FILE: hw/rtl/ess_pkg.sv
// Shared types, widths and constants for the encoder speed scaler.
`timescale 1ns / 1ps

package ess_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int TIME_W        = 32;
    localparam int ENC_W         = 16;
    localparam int CPR_W         = 16;
    localparam int MAXRPM_W      = 16;
    localparam int FS_W          = 10;
    localparam int MINIV_W       = 10;
    localparam int OUT_W         = FS_W + 1;
    localparam int RPM_FACTOR_W  = 16;
    localparam int PM_W          = CPR_W + MAXRPM_W;
    localparam int DEN_W         = PM_W + TIME_W;
    localparam int RATE_W        = COUNT_WIDTH + RPM_FACTOR_W;
    localparam int NUM_W         = RATE_W + FS_W;
    localparam int QW            = FS_W;
    localparam int QCNT_W        = $clog2(QW);
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 4;

    localparam logic [RPM_FACTOR_W-1:0] RPM_FACTOR = 16'd60000;

    localparam logic [CPR_W-1:0]    CPR_RESET    = 16'd350;
    localparam logic [MAXRPM_W-1:0] MAXRPM_RESET = 16'd600;
    localparam logic [FS_W-1:0]     FS_RESET     = 10'd999;
    localparam logic [MINIV_W-1:0]  MINIV_RESET  = 10'd1;

    typedef enum logic [1:0] {
        REG_COUNTS_PER_REV  = 2'd0,
        REG_MAX_RPM         = 2'd1,
        REG_FULL_SCALE      = 2'd2,
        REG_MIN_INTERVAL_MS = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DELTA,
        OP_MUL,
        OP_CHECK,
        OP_LOAD,
        OP_DIV,
        OP_EMIT,
        OP_REPEAT
    } t_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_SOON,
        COND_TRIVIAL,
        COND_MORE
    } t_cond;

    typedef struct packed {
        logic [CPR_W-1:0]    counts_per_rev;
        logic [MAXRPM_W-1:0] max_rpm;
        logic [FS_W-1:0]     full_scale;
        logic [MINIV_W-1:0]  min_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic fire;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic soon;
        logic trivial;
        logic more;
        logic slot_free;
    } t_stat;

endpackage

FILE: hw/rtl/encoder_speed_scaler.sv
// A transaction runs through the microcode steps delta, multiply, check, load, the divide
// loop and emit; a zero or saturated speed skips the divide, a too-soon sample repeats.
// No new transaction is taken until the last one has left its final step, which comes
// after the ten-step shift-subtract divide loop of the microcode; the output register
// frees the input side.
// Reset (synchronous, active low): registers return to 350/600/999/1, stored count,
// time and result clear to zero, the sequencer idles and o_valid drops.
`timescale 1ns / 1ps

module encoder_speed_scaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ess_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ess_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ess_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ess_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [ess_pkg::ENC_W-1:0]           i_encoder_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ess_pkg::OUT_W-1:0]    o_scaled_speed
);

    ess_pkg::t_cfg  cfg;
    ess_pkg::t_ctrl ctrl;
    ess_pkg::t_stat stat;
    logic           busy;

    ess_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ess_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    ess_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_ctrl          (ctrl),
        .i_time_ms       (i_time_ms),
        .i_encoder_count (i_encoder_count),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_scaled_speed  (o_scaled_speed)
    );

    assign o_stall = busy;

endmodule

FILE: hw/rtl/ess_cfg_regs.sv
// APB configuration register file for the encoder speed scaler.
`timescale 1ns / 1ps

module ess_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ess_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ess_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ess_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output ess_pkg::t_cfg                     o_cfg
);

    logic [ess_pkg::CPR_W-1:0]    r_cpr;
    logic [ess_pkg::MAXRPM_W-1:0] r_max_rpm;
    logic [ess_pkg::FS_W-1:0]     r_full_scale;
    logic [ess_pkg::MINIV_W-1:0]  r_min_iv;
    ess_pkg::t_reg                reg_sel;
    logic                         wr_en;

    assign reg_sel = ess_pkg::t_reg'(paddr[3:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr        <= ess_pkg::CPR_RESET;
            r_max_rpm    <= ess_pkg::MAXRPM_RESET;
            r_full_scale <= ess_pkg::FS_RESET;
            r_min_iv     <= ess_pkg::MINIV_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                ess_pkg::REG_COUNTS_PER_REV:  r_cpr        <= pwdata[ess_pkg::CPR_W-1:0];
                ess_pkg::REG_MAX_RPM:         r_max_rpm    <= pwdata[ess_pkg::MAXRPM_W-1:0];
                ess_pkg::REG_FULL_SCALE:      r_full_scale <= pwdata[ess_pkg::FS_W-1:0];
                ess_pkg::REG_MIN_INTERVAL_MS: r_min_iv     <= pwdata[ess_pkg::MINIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ess_pkg::REG_COUNTS_PER_REV:  prdata = ess_pkg::APB_DATA_W'(r_cpr);
            ess_pkg::REG_MAX_RPM:         prdata = ess_pkg::APB_DATA_W'(r_max_rpm);
            ess_pkg::REG_FULL_SCALE:      prdata = ess_pkg::APB_DATA_W'(r_full_scale);
            ess_pkg::REG_MIN_INTERVAL_MS: prdata = ess_pkg::APB_DATA_W'(r_min_iv);
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg.counts_per_rev  = r_cpr;
    assign o_cfg.max_rpm         = r_max_rpm;
    assign o_cfg.full_scale      = r_full_scale;
    assign o_cfg.min_interval_ms = r_min_iv;

endmodule

FILE: hw/rtl/ess_sequencer.sv
// Microcode ROM, step counter and jump logic for the encoder speed scaler.
`timescale 1ns / 1ps

module ess_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ess_pkg::t_stat i_stat,
    output ess_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);

    localparam int STEP_W = 3;

    typedef struct packed {
        ess_pkg::t_op     op;
        ess_pkg::t_cond   cond;
        logic [STEP_W-1:0] target;
        logic             last;
        logic             wait_out;
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: ess_pkg::OP_NOP, cond: ess_pkg::COND_NONE, target: '0,
              last: 1'b1, wait_out: 1'b0};
        case (step)
            3'd0: w = '{ess_pkg::OP_DELTA,  ess_pkg::COND_NONE,    3'd0, 1'b0, 1'b0};
            3'd1: w = '{ess_pkg::OP_MUL,    ess_pkg::COND_SOON,    3'd6, 1'b0, 1'b0};
            3'd2: w = '{ess_pkg::OP_CHECK,  ess_pkg::COND_NONE,    3'd0, 1'b0, 1'b0};
            3'd3: w = '{ess_pkg::OP_LOAD,   ess_pkg::COND_TRIVIAL, 3'd5, 1'b0, 1'b0};
            3'd4: w = '{ess_pkg::OP_DIV,    ess_pkg::COND_MORE,    3'd4, 1'b0, 1'b0};
            3'd5: w = '{ess_pkg::OP_EMIT,   ess_pkg::COND_NONE,    3'd0, 1'b1, 1'b1};
            3'd6: w = '{ess_pkg::OP_REPEAT, ess_pkg::COND_NONE,    3'd0, 1'b1, 1'b1};
            default: ;
        endcase
        return w;
    endfunction

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              fire;
    logic              take;
    logic              jump;

    assign uw   = ucode(r_step);
    assign fire = r_busy && (!uw.wait_out || i_stat.slot_free);

    always_comb begin
        case (uw.cond)
            ess_pkg::COND_NONE:    take = 1'b0;
            ess_pkg::COND_SOON:    take = i_stat.soon;
            ess_pkg::COND_TRIVIAL: take = i_stat.trivial;
            ess_pkg::COND_MORE:    take = i_stat.more;
            default:               take = 1'b0;
        endcase
    end

    assign jump   = take;
    assign n_step = jump ? uw.target : r_step + STEP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else if (fire) begin
            if (uw.last) begin
                r_busy <= 1'b0;
                r_step <= '0;
            end else begin
                r_step <= n_step;
            end
        end
    end

    assign o_ctrl.load = !r_busy && i_valid;
    assign o_ctrl.fire = fire;
    assign o_ctrl.op   = uw.op;
    assign o_busy      = r_busy;

`ifndef SYNTH
    a_busy_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && $past(i_rst_n) |-> $past(fire && uw.last))
        else $error("sequencer left a program without its last step");
    a_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !fire |=> $stable(r_step))
        else $error("step counter moved on a stalled step");
    a_div_loops_to_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && uw.op == ess_pkg::OP_DIV && i_stat.more |=> uw.op == ess_pkg::OP_DIV)
        else $error("divide loop exited early");
`endif

endmodule

FILE: hw/rtl/ess_datapath.sv
// Delta, multiply, serial divide and result registers of the speed scaler.
`timescale 1ns / 1ps

module ess_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ess_pkg::t_cfg                       i_cfg,
    input  ess_pkg::t_ctrl                      i_ctrl,
    input  logic [ess_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [ess_pkg::ENC_W-1:0]           i_encoder_count,
    input  logic                                i_stall,
    output ess_pkg::t_stat                      o_stat,
    output logic                                o_valid,
    output logic signed [ess_pkg::OUT_W-1:0]    o_scaled_speed
);

    localparam int CW = ess_pkg::COUNT_WIDTH;

    logic [ess_pkg::TIME_W-1:0] r_time;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_prev_count;
    logic [ess_pkg::TIME_W-1:0] r_prev_time;
    logic [ess_pkg::OUT_W-1:0]  r_prev_result;
    logic [ess_pkg::TIME_W-1:0] r_dt;
    logic                       r_soon;
    logic                       r_neg;
    logic [CW-1:0]              r_mag;
    logic [ess_pkg::PM_W-1:0]   r_pm;
    logic [ess_pkg::DEN_W-1:0]  r_den;
    logic [ess_pkg::RATE_W-1:0] r_rate;
    logic [ess_pkg::NUM_W-1:0]  r_num;
    logic                       r_zero;
    logic                       r_sat;
    logic [ess_pkg::DEN_W-1:0]  r_rem;
    logic [ess_pkg::QW-1:0]     r_nlo;
    logic [ess_pkg::QW-1:0]     r_quo;
    logic [ess_pkg::QCNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    logic [ess_pkg::OUT_W-1:0]  r_out;

    logic [ess_pkg::TIME_W-1:0] dt;
    logic [CW-1:0]              diff;
    logic [CW-1:0]              mag_c;
    logic [ess_pkg::DEN_W:0]    trial;
    logic [ess_pkg::DEN_W:0]    trial_sub;
    logic                       ge;
    logic [ess_pkg::DEN_W-1:0]  rem_next;
    logic [ess_pkg::FS_W-1:0]   emit_mag;
    logic [ess_pkg::OUT_W-1:0]  emit_pos;
    logic [ess_pkg::OUT_W-1:0]  result;
    logic                       slot_free;
    logic                       do_emit;
    logic                       do_repeat;

    assign dt    = r_time - r_prev_time;
    assign diff  = r_count - r_prev_count;
    assign mag_c = diff[CW-1] ? (CW'(0) - diff) : diff;

    assign trial     = {r_rem, r_nlo[ess_pkg::QW-1]};
    assign ge        = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};
    assign rem_next  = ge ? trial_sub[ess_pkg::DEN_W-1:0] : trial[ess_pkg::DEN_W-1:0];

    assign emit_mag = r_zero ? '0 : (r_sat ? i_cfg.full_scale : r_quo);
    assign emit_pos = ess_pkg::OUT_W'(emit_mag);
    assign result   = r_neg ? (ess_pkg::OUT_W'(0) - emit_pos) : emit_pos;

    assign slot_free = !r_out_valid || !i_stall;
    assign do_emit   = i_ctrl.fire && (i_ctrl.op == ess_pkg::OP_EMIT);
    assign do_repeat = i_ctrl.fire && (i_ctrl.op == ess_pkg::OP_REPEAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_prev_count  <= '0;
            r_prev_time   <= '0;
            r_prev_result <= '0;
        end else begin
            if (do_emit || do_repeat) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_emit) begin
                r_prev_count  <= r_count;
                r_prev_time   <= r_time;
                r_prev_result <= result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_time  <= i_time_ms;
            r_count <= CW'(i_encoder_count);
        end
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                ess_pkg::OP_DELTA: begin
                    r_dt   <= dt;
                    r_soon <= dt < ess_pkg::TIME_W'(i_cfg.min_interval_ms);
                    r_neg  <= diff[CW-1];
                    r_mag  <= mag_c;
                    r_pm   <= ess_pkg::PM_W'(i_cfg.counts_per_rev)
                            * ess_pkg::PM_W'(i_cfg.max_rpm);
                end
                ess_pkg::OP_MUL: begin
                    r_den  <= ess_pkg::DEN_W'(r_pm) * ess_pkg::DEN_W'(r_dt);
                    r_rate <= ess_pkg::RATE_W'(r_mag) * ess_pkg::RATE_W'(ess_pkg::RPM_FACTOR);
                end
                ess_pkg::OP_CHECK: begin
                    r_num  <= ess_pkg::NUM_W'(r_rate) * ess_pkg::NUM_W'(i_cfg.full_scale);
                    r_zero <= r_mag == '0;
                    r_sat  <= (r_den == '0) || (ess_pkg::DEN_W'(r_rate) >= r_den);
                end
                ess_pkg::OP_LOAD: begin
                    r_rem <= ess_pkg::DEN_W'(r_num >> ess_pkg::QW);
                    r_nlo <= r_num[ess_pkg::QW-1:0];
                    r_quo <= '0;
                    r_cnt <= ess_pkg::QCNT_W'(ess_pkg::QW - 1);
                end
                ess_pkg::OP_DIV: begin
                    r_rem <= rem_next;
                    r_nlo <= r_nlo << 1;
                    r_quo <= {r_quo[ess_pkg::QW-2:0], ge};
                    r_cnt <= r_cnt - ess_pkg::QCNT_W'(1);
                end
                ess_pkg::OP_EMIT:   r_out <= result;
                ess_pkg::OP_REPEAT: r_out <= r_prev_result;
                default: ;
            endcase
        end
    end

    assign o_stat.soon      = r_soon;
    assign o_stat.trivial   = r_zero || r_sat;
    assign o_stat.more      = r_cnt != '0;
    assign o_stat.slot_free = slot_free;

    assign o_valid        = r_out_valid;
    assign o_scaled_speed = r_out;

`ifndef SYNTH
    a_emit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_emit |-> emit_mag <= i_cfg.full_scale)
        else $error("emitted magnitude above full scale");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.fire && i_ctrl.op == ess_pkg::OP_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");
    a_repeat_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_repeat |=> $stable(r_prev_time) && $stable(r_prev_count)
                      && $stable(r_prev_result))
        else $error("too-soon sample changed stored state");
`endif

endmodule

FILE: tb/encoder_speed_scaler_tb.sv
// Self-checking testbench for encoder_speed_scaler: speed predictor, APB writes, random idling.
`timescale 1ns / 1ps

module encoder_speed_scaler_tb;

    class speed_scoreboard;
        logic [ess_pkg::CPR_W-1:0]    cpr;
        logic [ess_pkg::MAXRPM_W-1:0] rpm_max;
        logic [ess_pkg::FS_W-1:0]     fs;
        logic [ess_pkg::MINIV_W-1:0]  min_iv;
        logic [ess_pkg::ENC_W-1:0]    last_count;
        logic [ess_pkg::TIME_W-1:0]   last_stamp;
        logic [ess_pkg::OUT_W-1:0]    last_speed;
        logic [ess_pkg::OUT_W-1:0]    speed_q[$];
        int                           errors;
        int                           readings;
        int                           checked;

        function new();
            cpr        = ess_pkg::CPR_RESET;
            rpm_max    = ess_pkg::MAXRPM_RESET;
            fs         = ess_pkg::FS_RESET;
            min_iv     = ess_pkg::MINIV_RESET;
            last_count = '0;
            last_stamp = '0;
            last_speed = '0;
            errors     = 0;
            readings   = 0;
            checked    = 0;
        endfunction

        function void set_reg(ess_pkg::t_reg r, logic [31:0] v);
            case (r)
                ess_pkg::REG_COUNTS_PER_REV:  cpr     = v[ess_pkg::CPR_W-1:0];
                ess_pkg::REG_MAX_RPM:         rpm_max = v[ess_pkg::MAXRPM_W-1:0];
                ess_pkg::REG_FULL_SCALE:      fs      = v[ess_pkg::FS_W-1:0];
                ess_pkg::REG_MIN_INTERVAL_MS: min_iv  = v[ess_pkg::MINIV_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return speed_q.size();
        endfunction

        function void note_reading(logic [ess_pkg::TIME_W-1:0] stamp,
                                   logic [ess_pkg::ENC_W-1:0] count);
            logic [ess_pkg::TIME_W-1:0] dt;
            logic [ess_pkg::ENC_W-1:0]  diff;
            logic                       neg;
            logic [63:0]                mag;
            logic [63:0]                rate;
            logic [63:0]                denom;
            logic [63:0]                scaled;
            logic [ess_pkg::OUT_W-1:0]  speed;
            readings++;
            dt = stamp - last_stamp;
            if (dt < ess_pkg::TIME_W'(min_iv)) begin
                speed_q.push_back(last_speed);
            end else begin
                diff  = count - last_count;
                neg   = diff[ess_pkg::ENC_W-1];
                mag   = neg ? (64'd65536 - 64'(diff)) : 64'(diff);
                rate  = mag * 64'd60000;
                denom = 64'(cpr) * 64'(rpm_max) * 64'(dt);
                if (mag == 0) begin
                    scaled = 0;
                end else if (denom == 0 || rate >= denom) begin
                    scaled = 64'(fs);
                end else begin
                    scaled = (rate * 64'(fs)) / denom;
                    if (scaled > 64'(fs))
                        scaled = 64'(fs);
                end
                speed = scaled[ess_pkg::OUT_W-1:0];
                if (neg)
                    speed = -speed;
                last_count = count;
                last_stamp = stamp;
                last_speed = speed;
                speed_q.push_back(speed);
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_speed(logic signed [ess_pkg::OUT_W-1:0] got);
            logic signed [ess_pkg::OUT_W-1:0] want;
            checked++;
            if (speed_q.size() == 0) begin
                report($sformatf("speed %0d with no transaction outstanding", got));
            end else begin
                want = speed_q.pop_front();
                if (got !== want)
                    report($sformatf("scaled_speed %0d, predicted %0d", got, want));
            end
        endtask
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [ess_pkg::APB_ADDR_W-1:0]       paddr = '0;
    logic [ess_pkg::APB_DATA_W-1:0]       pwdata = '0;
    logic [ess_pkg::APB_DATA_W-1:0]       prdata;
    logic                                 pready;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [ess_pkg::TIME_W-1:0]           i_time_ms = '0;
    logic [ess_pkg::ENC_W-1:0]            i_encoder_count = '0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic signed [ess_pkg::OUT_W-1:0]     o_scaled_speed;

    speed_scoreboard sb;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              reg_writes = 0;

    encoder_speed_scaler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_time_ms       (i_time_ms),
        .i_encoder_count (i_encoder_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_scaled_speed  (o_scaled_speed)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null && o_valid && !i_stall)
            sb.check_speed(o_scaled_speed);
    end

    task automatic send_reading(logic [ess_pkg::TIME_W-1:0] stamp,
                                logic [ess_pkg::ENC_W-1:0] count);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_time_ms       <= stamp;
        i_encoder_count <= count;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_reading(stamp, count);
    endtask

    task automatic send_delta(logic [ess_pkg::TIME_W-1:0] dt,
                              logic [ess_pkg::ENC_W-1:0] delta);
        send_reading(sb.last_stamp + dt, sb.last_count + delta);
    endtask

    // Hold input low until every predicted speed has come back, then let the pipe settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(ess_pkg::t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ess_pkg::APB_ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_reg(r, v);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(int c, int m, int f, int iv);
        apb_write(ess_pkg::REG_COUNTS_PER_REV, c);
        apb_write(ess_pkg::REG_MAX_RPM, m);
        apb_write(ess_pkg::REG_FULL_SCALE, f);
        apb_write(ess_pkg::REG_MIN_INTERVAL_MS, iv);
    endtask

    task automatic send_random();
        int          pick;
        int          iv;
        logic [31:0] dt;
        logic [63:0] top;
        logic [31:0] mag;
        pick = $urandom_range(99);
        iv   = (sb.min_iv == 0) ? 1 : int'(sb.min_iv);
        if (pick < 12) begin
            send_reading(sb.last_stamp + $urandom_range(iv - 1, 0), 16'($urandom));
        end else if (pick < 20) begin
            send_reading($urandom, 16'($urandom));
        end else begin
            dt = (pick < 24) ? $urandom_range(32'hFFFF_FFFF, iv) : iv + $urandom_range(2 * iv + 4);
            top = (64'(sb.cpr) * 64'(sb.rpm_max) * 64'(dt)) / 64'd60000 + 64'd2;
            if (top > 64'd32768)
                top = 64'd32768;
            mag = (pick < 30) ? $urandom_range(32768) : $urandom_range(top[31:0]);
            if ($urandom_range(1))
                send_delta(dt, -mag[ess_pkg::ENC_W-1:0]);
            else
                send_delta(dt, mag[ess_pkg::ENC_W-1:0]);
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct  = 11;
        recv_stall_pct = 60;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_reading(32'd0, 16'h0000);
        send_reading(32'd1, 16'h0000);
        send_reading(32'd2, 16'h0001);
        send_reading(32'd3, 16'h0000);
        send_reading(32'd4, 16'h8000);
        send_reading(32'd5, 16'hFFFF);
        send_reading(32'd5, 16'h1234);
        send_reading(32'd3, 16'h0000);
        send_reading(32'hFFFF_FFFF, 16'hFFFF);
        send_reading(32'h0000_0000, 16'h0000);
        send_reading(32'hAAAA_AAAA, 16'h5555);
        send_reading(32'h5555_5555, 16'hAAAA);

        // Drive each divisor term to zero in turn.
        wait_idle();
        apb_write(ess_pkg::REG_COUNTS_PER_REV, 0);
        send_delta(1, 16'd5);
        send_delta(1, -16'd3);
        send_delta(1, 16'd0);
        wait_idle();
        apb_write(ess_pkg::REG_COUNTS_PER_REV, 350);
        apb_write(ess_pkg::REG_MAX_RPM, 0);
        send_delta(1, 16'd7);
        wait_idle();
        apb_write(ess_pkg::REG_MAX_RPM, 600);
        apb_write(ess_pkg::REG_MIN_INTERVAL_MS, 0);
        send_delta(0, -16'd2);
        send_delta(0, 16'd0);
        send_delta(0, 16'd9);

        for (int p = 0; p < 7; p++) begin
            wait_idle();
            case (p)
                0: load_config(350, 600, 999, 1);
                1: load_config(1, 1, 1023, 1000);
                2: load_config(65535, 65535, 1, 1);
                default: load_config($urandom_range(2000, 1), $urandom_range(3000, 1),
                                     $urandom_range(1023, 1), $urandom_range(20, 1));
            endcase
            if (p < 3) begin
                send_idle_pct  = 11;
                recv_stall_pct = 60;
            end else if (p < 5) begin
                send_idle_pct  = 60;
                recv_stall_pct = 11;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(99) < 2)
                    wait_idle();
                send_random();
            end
        end

        wait_idle();
        $display("Sent %0d encoder readings, checked %0d speeds, %0d register writes",
                 sb.readings, sb.checked, reg_writes);
        $display("Covered too-soon repeats, zero divisors, wrapped ticks, saturation");
        if (sb.errors == 0)
            $display("encoder_speed_scaler_tb: clean");
        else
            $display("encoder_speed_scaler_tb: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d speeds outstanding", (sb == null) ? 0 : sb.pending());
        $display("encoder_speed_scaler_tb: errors");
        $finish;
    end

endmodule
